[hw/rtl/positional_linked_list_assert.svh]
// Assertion macros for the positional linked list.
`ifndef POSITIONAL_LINKED_LIST_ASSERT_SVH
`define POSITIONAL_LINKED_LIST_ASSERT_SVH

`ifndef SYNTH
`define PLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLP_NEVER(lbl, cond, msg) \
  `PLP_ASSERT(lbl, !(cond), msg)
`else
`define PLP_ASSERT(lbl, prop, msg)
`define PLP_NEVER(lbl, cond, msg)
`endif

`endif

[hw/rtl/plp_pkg.sv]
package plp_pkg;

  localparam int LIST_DEPTH_DEF = 256;
  localparam int ACT_W          = 3;
  localparam int POS_W          = 9;
  localparam int KEY_W          = 32;
  localparam int ST_W           = 2;
  localparam int LEN_W          = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_READ   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

endpackage

[hw/rtl/positional_linked_list.sv]
// channel   | direction | handshake
// ----------+-----------+---------------------------------------------
// in_*      | input     | beat taken at clk edge with start && !busy
// out_*     | output    | one-cycle beat marked by out_valid
//
// Clear and rejected beats answer from idle; append and insert at head or
// tail go by the take state; remove at head by head and free; read, insert
// or remove at p first walk the links (one link read per cycle).
// rst_n is synchronous; no clearing pass, untouched cells tracked by a
// high-water mark. The receiver cannot stall; busy holds off new beats.
module positional_linked_list
  import plp_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  output logic [ST_W-1:0]         out_status,
  output logic signed [KEY_W-1:0] out_read_key,
  output logic [LEN_W-1:0]        out_length
);

`include "positional_linked_list_assert.svh"

  localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAKE,
    S_WALK,
    S_LINK,
    S_INS_B,
    S_RM_HEAD,
    S_RM_C,
    S_RM_N,
    S_RM_FREE,
    S_RD_KEY
  } state_t;

  // memories
  logic [AW-1:0]    link_mem [LIST_DEPTH];
  logic [KEY_W-1:0] key_mem  [LIST_DEPTH];
  logic [AW-1:0]    link_q, laddr_q;
  logic             fresh_q;
  logic [KEY_W-1:0] key_q;

  logic             link_we, key_we;
  logic [AW-1:0]    link_waddr, link_wdata, link_raddr, key_waddr, key_raddr;
  logic [KEY_W-1:0] key_wdata;

  state_t                  state_r, state_nxt;
  logic [ACT_W-1:0]        act_r, act_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [AW-1:0]           head_r, head_nxt, tail_r, tail_nxt, free_r, free_nxt;
  logic [AW-1:0]           cur_r, cur_nxt, newc_r, newc_nxt, rmc_r, rmc_nxt;
  logic [CW-1:0]           count_r, count_nxt, hw_r, hw_nxt;
  logic [POS_W-1:0]        steps_r, steps_nxt;
  logic                    pend_r, pend_nxt;
  logic                    at_zero_r, at_zero_nxt, at_end_r, at_end_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [KEY_W-1:0] out_read_key_r, out_read_key_nxt;
  logic [LEN_W-1:0]        out_length_r;

  logic [AW-1:0]    link_val, cur_c, laddr_inc;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic             full;

  // untouched cells still link to the next cell
  assign laddr_inc = (laddr_q == AW'(LIST_DEPTH - 1)) ? '0 : laddr_q + 1'b1;
  assign link_val  = fresh_q ? laddr_inc : link_q;
  assign cur_c     = pend_r ? link_val : cur_r;
  assign pos_ext   = CMP_W'(in_position);
  assign cnt_ext   = CMP_W'(count_r);
  assign full      = (count_r == CW'(LIST_DEPTH));

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q  <= link_mem[link_raddr];
    laddr_q <= link_raddr;
    fresh_q <= (CW'(link_raddr) >= hw_r);
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_q <= key_mem[key_raddr];
  end

  always_comb begin
    state_nxt        = state_r;
    act_nxt          = act_r;
    key_nxt          = key_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    free_nxt         = free_r;
    cur_nxt          = cur_r;
    newc_nxt         = newc_r;
    rmc_nxt          = rmc_r;
    count_nxt        = count_r;
    hw_nxt           = hw_r;
    steps_nxt        = steps_r;
    pend_nxt         = pend_r;
    at_zero_nxt      = at_zero_r;
    at_end_nxt       = at_end_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = ST_OK;
    out_read_key_nxt = '0;
    link_we          = 1'b0;
    link_waddr       = free_r;
    link_wdata       = free_r;
    link_raddr       = cur_c;
    key_we           = 1'b0;
    key_waddr        = free_r;
    key_wdata        = key_r;
    key_raddr        = cur_c;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt       = in_action;
          key_nxt       = in_key;
          out_valid_nxt = 1'b1;
          case (in_action) inside
            ACT_APPEND, ACT_INSERT: begin
              if (in_action == ACT_INSERT && pos_ext > cnt_ext) begin
                out_status_nxt = ST_BADPOS;
              end else if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_valid_nxt = 1'b0;
                at_end_nxt    = (in_action == ACT_APPEND) || (pos_ext == cnt_ext);
                at_zero_nxt   = (count_r == '0) ||
                                (in_action == ACT_INSERT && in_position == '0);
                steps_nxt     = in_position - 1'b1;
                link_raddr    = free_r;
                state_nxt     = S_TAKE;
              end
            end
            ACT_REMOVE, ACT_READ: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = ST_BADPOS;
              end else begin
                out_valid_nxt = 1'b0;
                cur_nxt       = head_r;
                pend_nxt      = 1'b0;
                if (in_action == ACT_READ) begin
                  steps_nxt = in_position;
                  state_nxt = S_WALK;
                end else if (in_position == '0) begin
                  link_raddr = head_r;
                  state_nxt  = S_RM_HEAD;
                end else begin
                  steps_nxt = in_position - 1'b1;
                  state_nxt = S_WALK;
                end
              end
            end
            ACT_CLEAR: begin
              if (count_r != '0) begin
                link_we    = 1'b1;
                link_waddr = tail_r;
                link_wdata = free_r;
                free_nxt   = head_r;
                count_nxt  = '0;
              end
            end
            default: out_status_nxt = ST_BADPOS;
          endcase
        end
      end

      S_TAKE: begin
        newc_nxt = free_r;
        free_nxt = link_val;
        if (CW'(free_r) == hw_r) begin
          hw_nxt = hw_r + 1'b1;
        end
        if (at_zero_r) begin
          link_we    = 1'b1;
          link_waddr = free_r;
          link_wdata = head_r;
          key_we     = 1'b1;
          head_nxt   = free_r;
          if (count_r == '0) begin
            tail_nxt = free_r;
          end
          count_nxt     = count_r + 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (at_end_r) begin
          // tail link is never followed, so the new cell's link stays as is
          link_we       = 1'b1;
          link_waddr    = tail_r;
          link_wdata    = free_r;
          key_we        = 1'b1;
          tail_nxt      = free_r;
          count_nxt     = count_r + 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cur_nxt   = head_r;
          pend_nxt  = 1'b0;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        cur_nxt = cur_c;
        if (steps_r != '0) begin
          steps_nxt = steps_r - 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          case (act_r)
            ACT_READ:   state_nxt = S_RD_KEY;
            ACT_REMOVE: state_nxt = S_RM_C;
            default:    state_nxt = S_LINK;
          endcase
        end
      end

      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = newc_r;
        link_wdata = link_val;
        key_we     = 1'b1;
        key_waddr  = newc_r;
        state_nxt  = S_INS_B;
      end

      S_INS_B: begin
        link_we       = 1'b1;
        link_waddr    = cur_r;
        link_wdata    = newc_r;
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_RM_HEAD: begin
        rmc_nxt  = head_r;
        head_nxt = link_val;
        if (head_r == tail_r) begin
          tail_nxt = link_val;
        end
        state_nxt = S_RM_FREE;
      end

      S_RM_C: begin
        rmc_nxt    = link_val;
        link_raddr = link_val;
        state_nxt  = S_RM_N;
      end

      S_RM_N: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = link_val;
        if (rmc_r == tail_r) begin
          tail_nxt = cur_r;
        end
        state_nxt = S_RM_FREE;
      end

      S_RM_FREE: begin
        link_we       = 1'b1;
        link_waddr    = rmc_r;
        link_wdata    = free_r;
        free_nxt      = rmc_r;
        count_nxt     = count_r - 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_RD_KEY: begin
        out_read_key_nxt = key_q;
        out_valid_nxt    = 1'b1;
        state_nxt        = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      count_r     <= '0;
      hw_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      hw_r        <= hw_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r          <= act_nxt;
    key_r          <= key_nxt;
    cur_r          <= cur_nxt;
    newc_r         <= newc_nxt;
    rmc_r          <= rmc_nxt;
    steps_r        <= steps_nxt;
    at_zero_r      <= at_zero_nxt;
    at_end_r       <= at_end_nxt;
    out_status_r   <= out_status_nxt;
    out_read_key_r <= out_read_key_nxt;
    out_length_r   <= LEN_W'(count_nxt);
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_read_key = out_read_key_r;
  assign out_length   = out_length_r;

  `PLP_ASSERT(a_count_le_hw, count_r <= hw_r, "list holds a cell never allocated")
  `PLP_ASSERT(a_hw_le_depth, hw_r <= CW'(LIST_DEPTH), "high-water mark past pool")
  `PLP_NEVER(a_out_while_busy, out_valid_r && busy, "result beat while still busy")
  `PLP_ASSERT(a_out_cause, out_valid_r |-> $past(busy) || $past(start), "result without a beat")

endmodule
